// File: src/c3rm_pkg.sv
// Shared types and constants for the 3x3 conv, requantize and max-pool block.
package c3rm_pkg;
  localparam logic [1:0] FUNC_WR_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_WR_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_WR_ACT    = 2'd2;
  localparam logic [1:0] FUNC_QUERY     = 2'd3;
  localparam int unsigned KSIZE = 3;
  localparam logic [6:0] CLAMP_MAX = 7'd127;

  // Controller to datapath commands.
  typedef struct packed {
    logic       start;    // capture the query and clear the pooled max
    logic       pix_init; // load bias into the accumulator
    logic       rd;       // issue one tap/lane-block read
    logic       mac;      // accumulate the previous read
    logic       req;      // start requantization of the finished pixel
    logic       fold;     // fold the requantized pixel into the max
  } c3rm_cmd_t;
endpackage

// File: src/c3rm_ctrl.sv
// Controller: sequences pixels, taps and lane blocks of one query.
module c3rm_ctrl import c3rm_pkg::*; #(
  parameter int unsigned NBLK = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  output logic       busy,
  output logic       done,
  output logic [1:0] pix,
  output logic [1:0] ky,
  output logic [1:0] kx,
  output logic [$clog2(NBLK+1)-1:0] blk,
  output c3rm_cmd_t  cmd
);
  localparam int BW = $clog2(NBLK + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_RUN = 3'd2,
                         S_LAST = 3'd3, S_REQ1 = 3'd4, S_REQ2 = 3'd5, S_FOLD = 3'd6;
  logic [2:0] state_r, state_nxt;
  logic [1:0] pix_r, pix_nxt, ky_r, ky_nxt, kx_r, kx_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic last_tap;

  assign last_tap = (ky_r == 2'd2) && (kx_r == 2'd2) && (blk_r == BW'(NBLK - 1));

  always_comb begin
    state_nxt = state_r;
    pix_nxt = pix_r; ky_nxt = ky_r; kx_nxt = kx_r; blk_nxt = blk_r;
    cmd = '0;
    done = 1'b0;
    unique case (state_r)
      S_IDLE: if (go) begin
        cmd.start = 1'b1;
        pix_nxt = 2'd0;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.pix_init = 1'b1;
        ky_nxt = 2'd0; kx_nxt = 2'd0; blk_nxt = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.rd = 1'b1;
        if (blk_r != BW'(NBLK - 1)) blk_nxt = blk_r + 1'b1;
        else begin
          blk_nxt = '0;
          if (kx_r != 2'd2) kx_nxt = kx_r + 2'd1;
          else begin
            kx_nxt = 2'd0;
            ky_nxt = ky_r + 2'd1;
          end
        end
        if (last_tap) state_nxt = S_LAST;
      end
      S_LAST: begin
        cmd.mac = 1'b1;
        state_nxt = S_REQ1;
      end
      S_REQ1: begin
        cmd.req = 1'b1;
        state_nxt = S_REQ2;
      end
      S_REQ2: state_nxt = S_FOLD;
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (pix_r == 2'd3) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pix_nxt = pix_r + 2'd1;
          state_nxt = S_INIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // accumulate the previous cycle's read while still reading
    if (state_r == S_RUN && !(ky_r == 2'd0 && kx_r == 2'd0 && blk_r == '0))
      cmd.mac = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pix_r <= '0; ky_r <= '0; kx_r <= '0; blk_r <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r <= pix_nxt; ky_r <= ky_nxt; kx_r <= kx_nxt; blk_r <= blk_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign pix = pix_r;
  assign ky = ky_r;
  assign kx = kx_r;
  assign blk = blk_r;
endmodule

// File: src/c3rm_datapath.sv
// Datapath: stores, lane multipliers, accumulator, requantization and max.
module c3rm_datapath import c3rm_pkg::*; #(
  parameter int unsigned IN_CHANNELS  = 16,
  parameter int unsigned OUT_CHANNELS = 32,
  parameter int unsigned FRAME_SIZE   = 48,
  parameter int unsigned IC_LANES     = 8,
  parameter int unsigned NBLK         = 2
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [1:0]         wr_func,
  input  logic [4:0]         wr_oc,
  input  logic [3:0]         wr_ic,
  input  logic [1:0]         wr_tr,
  input  logic [1:0]         wr_tc,
  input  logic [5:0]         wr_pr,
  input  logic [5:0]         wr_pc,
  input  logic signed [7:0]  wr_small,
  input  logic signed [31:0] wr_bias,
  input  logic signed [31:0] mult,
  input  logic [5:0]         shamt,
  input  c3rm_cmd_t          cmd,
  input  logic [1:0]         pix,
  input  logic [1:0]         ky,
  input  logic [1:0]         kx,
  input  logic [$clog2(NBLK+1)-1:0] blk,
  output logic [6:0]         pooled
);
  localparam int OCW  = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int FW   = $clog2(FRAME_SIZE + 2);
  localparam int BW   = $clog2(NBLK + 1);
  localparam int BIW  = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int LW   = (IC_LANES > 1) ? $clog2(IC_LANES) : 1;
  localparam int WROW = OUT_CHANNELS * KSIZE * KSIZE * NBLK;
  localparam int AROW = FRAME_SIZE * FRAME_SIZE * NBLK;
  localparam int WAW  = $clog2(WROW + 1);
  localparam int AAW  = $clog2(AROW + 1);
  localparam int SEW  = 18 + $clog2(IC_LANES + 1);

  // One row holds one lane block of channels.
  logic [IC_LANES*8-1:0] wmem [WROW];
  logic [IC_LANES*8-1:0] amem [AROW];
  logic [31:0]           bmem [OUT_CHANNELS];
  logic [IC_LANES*8-1:0] wq_r, aq_r;
  logic                  zero_r;

  logic [OCW-1:0] q_oc_r;
  logic [FW-1:0]  q_y0_r, q_x0_r;
  logic           q_oor_r;

  // write decode
  logic [BIW-1:0] wblk;
  logic [LW-1:0]  wlane;
  logic           w_ok, a_ok, b_ok;
  logic [WAW-1:0] w_waddr;
  logic [AAW-1:0] a_waddr;
  always_comb begin
    // split the channel into lane block and lane by compare and subtract
    wblk  = '0;
    wlane = LW'(wr_ic);
    for (int b = 1; b < NBLK; b++) begin
      if (32'(wr_ic) >= b * IC_LANES) begin
        wblk  = BIW'(b);
        wlane = LW'(32'(wr_ic) - b * IC_LANES);
      end
    end
    w_ok = wr_en && wr_func == FUNC_WR_WEIGHT && 32'(wr_oc) < OUT_CHANNELS &&
           32'(wr_ic) < IN_CHANNELS && wr_tr < 2'd3 && wr_tc < 2'd3;
    b_ok = wr_en && wr_func == FUNC_WR_BIAS && 32'(wr_oc) < OUT_CHANNELS;
    a_ok = wr_en && wr_func == FUNC_WR_ACT && 32'(wr_pr) < FRAME_SIZE &&
           32'(wr_pc) < FRAME_SIZE && 32'(wr_ic) < IN_CHANNELS;
    w_waddr = WAW'(((32'(wr_oc) * KSIZE + 32'(wr_tr)) * KSIZE + 32'(wr_tc)) * NBLK
                   + 32'(wblk));
    a_waddr = AAW'((32'(wr_pr) * FRAME_SIZE + 32'(wr_pc)) * NBLK + 32'(wblk));
  end

  // tap address
  logic [FW:0]    iy, ix;
  logic           tap_in;
  logic [WAW-1:0] w_raddr;
  logic [AAW-1:0] a_raddr;
  always_comb begin
    iy = {1'b0, q_y0_r} + {{FW{1'b0}}, pix[1]} + {{(FW-1){1'b0}}, ky};
    ix = {1'b0, q_x0_r} + {{FW{1'b0}}, pix[0]} + {{(FW-1){1'b0}}, kx};
    tap_in = iy >= (FW+1)'(1) && iy <= (FW+1)'(FRAME_SIZE) &&
             ix >= (FW+1)'(1) && ix <= (FW+1)'(FRAME_SIZE);
    w_raddr = WAW'(((32'(q_oc_r) * KSIZE + 32'(ky)) * KSIZE + 32'(kx)) * NBLK + 32'(blk));
    a_raddr = AAW'(((32'(iy) - 1) * FRAME_SIZE + (32'(ix) - 1)) * NBLK + 32'(blk));
  end

  always_ff @(posedge clk) begin
    if (w_ok) wmem[w_waddr][32'(wlane)*8 +: 8] <= wr_small;
    if (a_ok) amem[a_waddr][32'(wlane)*8 +: 8] <= wr_small;
    if (b_ok) bmem[OCW'(wr_oc)] <= wr_bias;
    wq_r <= wmem[w_raddr];
    if (tap_in) aq_r <= amem[a_raddr];
    zero_r <= !tap_in;
  end

  // lane products, summed; channels beyond IN_CHANNELS count as zero
  logic signed [SEW-1:0] lsum;
  logic [BW-1:0]         blk_d_r;
  always_comb begin
    lsum = '0;
    for (int l = 0; l < IC_LANES; l++) begin
      if (32'(blk_d_r) * IC_LANES + l < IN_CHANNELS)
        lsum = lsum + SEW'($signed(aq_r[l*8 +: 8]) * $signed(wq_r[l*8 +: 8]));
    end
  end

  logic [31:0]        acc_r;
  logic signed [63:0] prod_r, sh_r;
  logic [6:0]         clamp, max_r;
  always_comb begin
    if (sh_r[31]) clamp = 7'd0;
    else if (sh_r[30:7] != '0) clamp = CLAMP_MAX;
    else clamp = sh_r[6:0];
  end

  always_ff @(posedge clk) begin
    blk_d_r <= blk;
    if (cmd.start) begin
      q_oc_r  <= OCW'(wr_oc);
      q_y0_r  <= FW'({wr_pr, 1'b0});
      q_x0_r  <= FW'({wr_pc, 1'b0});
      q_oor_r <= !(32'(wr_oc) < OUT_CHANNELS && 32'(wr_pr) < FRAME_SIZE / 2 &&
                   32'(wr_pc) < FRAME_SIZE / 2);
      max_r   <= '0;
    end
    if (cmd.pix_init) acc_r <= bmem[q_oc_r];
    else if (cmd.mac && !zero_r) acc_r <= acc_r + 32'(lsum);
    if (cmd.req) prod_r <= $signed(acc_r) * mult;
    sh_r <= prod_r >>> shamt;
    if (cmd.fold && !q_oor_r && clamp > max_r) max_r <= clamp;
  end

  assign pooled = max_r;
endmodule

// File: src/conv3x3_same_requant_maxpool_top.sv
// Top level: INT8 3x3 SAME conv, requantize, ReLU clamp, 2x2 max pool.
// The controller reads one lane block per cycle from the weight and activation
// memories (NBLK = ceil(IN_CHANNELS/IC_LANES) lane blocks per tap).
// The result sits in an output register; the next word is taken meanwhile.
// Synchronous reset clears control and sets the multiplier to 1 and the shift to 0; stores are not cleared.
module conv3x3_same_requant_maxpool_top import c3rm_pkg::*; #(
  parameter int unsigned IN_CHANNELS  = 16,
  parameter int unsigned OUT_CHANNELS = 32,
  parameter int unsigned FRAME_SIZE   = 48,
  parameter int unsigned IC_LANES     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [4:0]         in_out_channel,
  input  logic [3:0]         in_in_channel,
  input  logic [1:0]         in_tap_row,
  input  logic [1:0]         in_tap_col,
  input  logic [5:0]         in_pos_row,
  input  logic [5:0]         in_pos_col,
  input  logic signed [7:0]  in_small_value,
  input  logic signed [31:0] in_bias_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_pooled_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int unsigned NBLK = (IN_CHANNELS + IC_LANES - 1) / IC_LANES;
  localparam logic CFG_MULT = 1'b0;
  localparam logic CFG_SHIFT = 1'b1;

  logic signed [31:0] mult_r;
  logic [5:0]         shift_r;
  logic               busy, done, acc, go, ov_r, hold_r;
  logic [1:0]         pix, ky, kx;
  logic [$clog2(NBLK+1)-1:0] blk;
  c3rm_cmd_t          cmd;
  logic [6:0]         pooled, res_r;

  // a finished query waits in hold_r until the output register frees up
  assign in_ready = !busy && !hold_r;
  assign acc = in_valid && in_ready;
  assign go = acc && in_func == FUNC_QUERY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= 32'sd1;
      shift_r <= '0;
      ov_r <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MULT:  mult_r <= cfg_data;
          CFG_SHIFT: shift_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (hold_r && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
        hold_r <= 1'b0;
      end else begin
        if (out_valid && out_ready) ov_r <= 1'b0;
        if (done) hold_r <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (hold_r && (!ov_r || out_ready)) res_r <= pooled;
  end
  assign out_valid = ov_r;
  assign out_pooled_value = res_r;

  c3rm_ctrl #(.NBLK(NBLK)) u_ctrl (
    .clk, .rst_n, .go, .busy, .done, .pix, .ky, .kx, .blk, .cmd
  );

  c3rm_datapath #(
    .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS),
    .FRAME_SIZE(FRAME_SIZE), .IC_LANES(IC_LANES), .NBLK(NBLK)
  ) u_dp (
    .clk, .wr_en(acc), .wr_func(in_func), .wr_oc(in_out_channel),
    .wr_ic(in_in_channel), .wr_tr(in_tap_row), .wr_tc(in_tap_col),
    .wr_pr(in_pos_row), .wr_pc(in_pos_col), .wr_small(in_small_value),
    .wr_bias(in_bias_value), .mult(mult_r), .shamt(shift_r), .cmd,
    .pix, .ky, .kx, .blk, .pooled
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("input taken during query");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> hold_r) else $error("finished query not held");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy) else $error("query did not start");
endmodule
